// ----- src/udhe_pkg.sv -----
// Package for the URL decoder and HTML escaper: types, codes and
// character tables shared by the decoder, emitter, top and testbench. No dependencies.
`default_nettype none

package udhe_pkg;

  // Saturation point of the decoded-byte counter.
  localparam int unsigned LengthLimitDef = 4096;

  localparam int unsigned LenW = 12;  // width of min_length and max_length
  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0] ChPercent = 8'h25;  // '%'
  localparam logic [7:0] ChPlus    = 8'h2B;  // '+'
  localparam logic [7:0] ChStar    = 8'h2A;  // '*'
  localparam logic [7:0] ChMinus   = 8'h2D;  // '-'
  localparam logic [7:0] ChUnder   = 8'h5F;  // '_'
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChAmp     = 8'h26;  // '&'
  localparam logic [7:0] ChLt      = 8'h3C;  // '<'
  localparam logic [7:0] ChGt      = 8'h3E;  // '>'
  localparam logic [7:0] ChSemi    = 8'h3B;  // ';'
  localparam logic [7:0] ChNul     = 8'h00;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INV_ENC   = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_TOO_SHORT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HI   = 2'd1,
    PH_LO   = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_LENGTH = 2'd0,
    CFG_MAX_LENGTH = 2'd1
  } cfg_idx_e;

  // One decoded byte to be escaped, or the end-of-string status.
  typedef struct packed {
    logic    is_status;
    logic [7:0] data;
    status_e status;
  } job_t;

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    return r;
  endfunction

  function automatic logic plain_char(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == ChStar || b == ChMinus ||
           b == ChUnder;
  endfunction

  // Number of output bytes a decoded byte expands to.
  function automatic logic [2:0] esc_len(input logic [7:0] b);
    logic [2:0] n;
    case (b)
      ChAmp:      n = 3'd5;
      ChLt, ChGt: n = 3'd4;
      default:    n = 3'd1;
    endcase
    return n;
  endfunction

  // Byte at position idx of the escaped form of b.
  function automatic logic [7:0] esc_char(input logic [7:0] b, input logic [2:0] idx);
    logic [7:0] c;
    c = b;
    case (b)
      ChAmp: begin
        case (idx)
          3'd0:    c = ChAmp;
          3'd1:    c = 8'h61;  // 'a'
          3'd2:    c = 8'h6D;  // 'm'
          3'd3:    c = 8'h70;  // 'p'
          default: c = ChSemi;
        endcase
      end
      ChLt, ChGt: begin
        case (idx)
          3'd0:    c = ChAmp;
          3'd1:    c = (b == ChLt) ? 8'h6C : 8'h67;  // 'l' or 'g'
          3'd2:    c = 8'h74;  // 't'
          default: c = ChSemi;
        endcase
      end
      default: c = b;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/udhe_in_if.sv -----
// Input channel: one source character per beat with valid/ready.
// Depends on nothing.
`default_nettype none

interface udhe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink (input valid, input src_byte, output ready);
endinterface

`default_nettype wire

// ----- src/udhe_out_if.sv -----
// Result channel: one escaped byte or status per beat with valid/ready.
// Depends on nothing.
`default_nettype none

interface udhe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_status;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output is_status, output status,
                  output last, input ready);
  modport sink (input valid, input out_byte, input is_status, input status,
                input last, output ready);
endinterface

`default_nettype wire

// ----- src/udhe_decoder.sv -----
// Percent decoder, length counter and configuration registers; holds one
// pending job for the emitter. Depends on udhe_pkg.
`default_nettype none

module udhe_decoder import udhe_pkg::*; #(
  parameter int unsigned LengthLimit = LengthLimitDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [LenW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         in_byte_i,
  output      logic               in_ready_o,
  output      logic               job_valid_o,
  output      job_t               job_o,
  input  wire logic               job_pop_i
);

  localparam int unsigned CntW = $clog2(LengthLimit + 1);
  localparam int unsigned CmpW = (CntW > LenW) ? CntW : LenW;

  phase_e          phase_q, phase_d;
  logic [3:0]      nib_q, nib_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            err_q, err_d;
  logic [LenW-1:0] min_q, max_q;
  logic            job_valid_q, job_valid_d;
  job_t            job_q, job_d;

  logic            in_fire;
  logic [4:0]      hx;
  logic            emit;
  logic [7:0]      emit_byte;
  logic [7:0]      dec_byte;
  logic            err_now;
  status_e         st;
  logic [CmpW-1:0] cnt_ext, min_ext, max_ext;

  // The pending job slot frees up in the same cycle the emitter takes it.
  assign in_ready_o = !job_valid_q || job_pop_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign hx         = hex_value(in_byte_i);
  assign dec_byte   = {nib_q, hx[3:0]};

  assign cnt_ext = CmpW'(cnt_q);
  assign min_ext = CmpW'(min_q);
  assign max_ext = CmpW'(max_q);

  always_comb begin
    err_now = err_q || (phase_q != PH_IDLE);
    if (err_now) st = ST_INV_ENC;
    else if (cnt_ext > max_ext) st = ST_TOO_LONG;
    else if (cnt_ext < min_ext) st = ST_TOO_SHORT;
    else st = ST_OK;
  end

  always_comb begin
    phase_d     = phase_q;
    nib_d       = nib_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    emit        = 1'b0;
    emit_byte   = in_byte_i;
    job_valid_d = job_valid_q && !job_pop_i;
    job_d       = job_q;

    if (in_fire) begin
      if (in_byte_i == ChNul) begin
        job_valid_d = 1'b1;
        job_d       = '{is_status: 1'b1, data: ChNul, status: st};
        phase_d     = PH_IDLE;
        nib_d       = 4'd0;
        cnt_d       = '0;
        err_d       = 1'b0;
      end else if (!err_q) begin
        unique case (phase_q)
          PH_HI: begin
            if (!hx[4]) begin
              err_d   = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              nib_d   = hx[3:0];
              phase_d = PH_LO;
            end
          end
          PH_LO: begin
            phase_d = PH_IDLE;
            if (!hx[4]) begin
              err_d = 1'b1;
            end else begin
              nib_d = 4'd0;
              if (dec_byte == ChNul) begin
                err_d = 1'b1;
              end else begin
                emit      = 1'b1;
                emit_byte = dec_byte;
              end
            end
          end
          default: begin
            if (in_byte_i == ChPercent) begin
              phase_d = PH_HI;
            end else if (in_byte_i == ChPlus) begin
              emit      = 1'b1;
              emit_byte = ChSpace;
            end else if (plain_char(in_byte_i)) begin
              emit = 1'b1;
            end else begin
              err_d = 1'b1;
            end
          end
        endcase
        if (emit) begin
          if (cnt_q < CntW'(LengthLimit)) cnt_d = cnt_q + 1'b1;
          job_valid_d = 1'b1;
          job_d       = '{is_status: 1'b0, data: emit_byte, status: ST_OK};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      nib_q       <= 4'd0;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      nib_q       <= nib_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_LENGTH: min_q <= cfg_data_i;
        CFG_MAX_LENGTH: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

`default_nettype wire

// ----- src/udhe_emitter.sv -----
// Output stage: expands one job into its escaped bytes, one beat per cycle
// while the receiver is ready. Depends on udhe_pkg.
`default_nettype none

module udhe_emitter import udhe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  wire job_t job_i,
  output      logic job_pop_o,
  output      logic out_valid_o,
  input  wire logic out_ready_i,
  output      logic [7:0] out_byte_o,
  output      logic out_is_status_o,
  output      logic [1:0] out_status_o,
  output      logic out_last_o
);

  logic       valid_q, valid_d;
  job_t       job_q, job_d;
  logic [2:0] idx_q, idx_d;
  logic       last_beat;
  logic       out_fire;

  assign last_beat = job_q.is_status || (idx_q == esc_len(job_q.data) - 3'd1);
  assign out_fire  = valid_q && out_ready_i;
  assign job_pop_o = job_valid_i && (!valid_q || (out_fire && last_beat));

  always_comb begin
    valid_d = valid_q;
    job_d   = job_q;
    idx_d   = idx_q;
    if (job_pop_o) begin
      valid_d = 1'b1;
      job_d   = job_i;
      idx_d   = 3'd0;
    end else if (out_fire) begin
      if (last_beat) valid_d = 1'b0;
      else idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = job_q.is_status ? ChNul : esc_char(job_q.data, idx_q);
  assign out_is_status_o = job_q.is_status;
  assign out_status_o    = job_q.is_status ? job_q.status : ST_OK;
  assign out_last_o      = last_beat;

endmodule

`default_nettype wire

// ----- src/url_decode_html_escape_validator.sv -----
// Top level of the form-field decoder and HTML escaper.
// Depends on udhe_pkg, udhe_in_if, udhe_out_if, udhe_decoder, udhe_emitter.
//
// Usage: the input channel carries one source character per beat; a zero
// byte ends the string. Percent escapes are decoded, '+' becomes a space,
// and every decoded byte streams out at once on the result channel, with
// '&', '<' and '>' expanded to their HTML entities (five or four beats).
// The terminating zero byte yields one status beat (is_status set) giving
// ok, invalid encoding, too long or too short. The consumer keeps the
// streamed bytes only if that status is ok. The last flag marks the final
// beat caused by each input character.
// An accepted character is held in the decoder's job register, moves into the
// emitter's register when the emitter takes it, and its first beat goes out from there.
// The emitter sends one beat per cycle while the receiver is ready and takes the
// next job as the last beat of the current one goes out; a character expands to
// one to five beats, and a character that yields nothing sends none.
// A stalled receiver freezes the emitter; the job register still takes one more
// character that yields output, after which input ready drops.
// Reset clears the decode state, the length counter, both pipeline slots
// and sets min_length to 0 and max_length to 4095. Configuration writes go
// through a plain write port and are meant to happen only while idle.
`default_nettype none

module url_decode_html_escape_validator import udhe_pkg::*; #(
  parameter int unsigned LengthLimit = LengthLimitDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [LenW-1:0]    cfg_data_i,
  udhe_in_if.sink                 in_if,
  udhe_out_if.source              out_if
);

  // Handoff between the decoder's job register and the emitter.
  logic job_valid;
  job_t job;
  logic job_pop;

  udhe_decoder #(
    .LengthLimit(LengthLimit)
  ) u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_if.valid),
    .in_byte_i   (in_if.src_byte),
    .in_ready_o  (in_if.ready),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  // The emitter is the output register; it walks through the entity bytes.
  udhe_emitter u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (job),
    .job_pop_o       (job_pop),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .out_byte_o      (out_if.out_byte),
    .out_is_status_o (out_if.is_status),
    .out_status_o    (out_if.status),
    .out_last_o      (out_if.last)
  );

  // A terminating zero byte always leaves a status job behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && in_if.src_byte == ChNul |=> job_valid && job.is_status)
    else $error("end of string did not produce a status job");

  // A pending job that the emitter does not take must stay unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && !job_pop |=> job_valid && $stable(job))
    else $error("pending job lost or altered");

  // Status beats are single beats with a zero data byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.is_status |-> out_if.last && out_if.out_byte == ChNul)
    else $error("malformed status beat");

endmodule

`default_nettype wire

// ----- test/url_decode_html_escape_validator_tb.sv -----
// Testbench for url_decode_html_escape_validator: drives form-encoded strings,
// predicts the escaped byte stream and status beats, and checks every beat.
// Depends on udhe_pkg, udhe_in_if, udhe_out_if and the block itself.
`timescale 1ns / 1ps

module url_decode_html_escape_validator_tb;
  import udhe_pkg::*;

  // A cycle count with no beat on either channel that ends the run.
  localparam int WatchdogLimit = 2000;
  // Quiet cycles after the last expected beat, in which the monitor still
  // checks any beat that the job register or the emitter sends.
  localparam int DrainCycles = 8;
  // Beats of random stimulus that the block acts on (ignored ones do not count).
  localparam int RandomItems = 400;
  // Only this many mismatch lines are printed; all of them are counted.
  localparam int PrintLimit = 20;

  // Register indexes that the block does not implement; writes must be dropped.
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

  // One beat on the result channel.
  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    status_e    status;
    logic       last;
  } beat_t;

  // How the receiver throttles the result channel.
  typedef enum int {
    RX_FREE,    // always ready
    RX_THIRD,   // ready when the tick counter is a multiple of three
    RX_COIN,    // ready at random
    RX_BURSTY   // long closed runs broken by short open runs
  } rx_mode_e;

  // Ways to break a string on purpose.
  typedef enum int {
    FL_NONE,
    FL_BAD_CHAR,  // a byte outside the accepted set
    FL_BAD_HI,    // non-hex first digit after the percent sign
    FL_BAD_LO,    // non-hex second digit
    FL_NUL_ESC,   // the escape for a zero byte
    FL_CUT_HI,    // string ends right after the percent sign
    FL_CUT_LO     // string ends after the first hex digit
  } flaw_e;

  // Predicts the escaped stream from accepted characters and checks each
  // result beat against the oldest prediction.
  class decode_scoreboard;
    logic [LenW-1:0] min_len;
    logic [LenW-1:0] max_len;
    phase_e          phase;
    logic [3:0]      hi_nib;
    int unsigned     count;
    bit              bad;
    beat_t           pending_beats[$];
    int              errors;
    int              live_items;
    int              strings_done;
    int              bytes_out;
    int              status_seen[4];

    function new();
      min_len = '0;
      max_len = '1;
      phase = PH_IDLE;
      hi_nib = '0;
      count = 0;
      bad = 0;
      errors = 0;
      live_items = 0;
      strings_done = 0;
      bytes_out = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function bit is_hex(logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function logic [3:0] hex_nibble(logic [7:0] b);
      logic [7:0] d;
      if (b <= "9") d = b - "0";
      else if (b <= "F") d = b - "A" + 8'd10;
      else d = b - "a" + 8'd10;
      return d[3:0];
    endfunction

    function bit is_plain(logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             b == ChStar || b == ChMinus || b == ChUnder;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] val);
      if (idx == CFG_MIN_LENGTH) min_len = val;
      else if (idx == CFG_MAX_LENGTH) max_len = val;
    endfunction

    // One decoded byte: count it and queue its HTML-escaped form.
    function void emit(logic [7:0] v);
      string ent;
      if (count < LengthLimitDef) count++;
      case (v)
        ChAmp:   ent = "&amp;";
        ChLt:    ent = "&lt;";
        ChGt:    ent = "&gt;";
        default: ent = "";
      endcase
      if (ent.len() == 0) begin
        pending_beats.push_back('{data: v, is_status: 1'b0, status: ST_OK, last: 1'b1});
      end else begin
        for (int i = 0; i < ent.len(); i++) begin
          pending_beats.push_back('{data: ent[i], is_status: 1'b0, status: ST_OK,
                                    last: (i == ent.len() - 1)});
        end
      end
    endfunction

    function void take_char(logic [7:0] b);
      status_e st;
      logic [7:0] v;
      if (b == ChNul) begin
        live_items++;
        // A string that ends inside an escape counts as badly encoded.
        if (phase != PH_IDLE) bad = 1;
        if (bad) st = ST_INV_ENC;
        else if (count > max_len) st = ST_TOO_LONG;
        else if (count < min_len) st = ST_TOO_SHORT;
        else st = ST_OK;
        pending_beats.push_back('{data: 8'h00, is_status: 1'b1, status: st, last: 1'b1});
        phase = PH_IDLE;
        hi_nib = '0;
        count = 0;
        bad = 0;
        return;
      end
      // Once the string is known to be bad, the rest of it is dropped silently.
      if (bad) return;
      live_items++;
      case (phase)
        PH_HI: begin
          if (!is_hex(b)) begin
            bad = 1;
            phase = PH_IDLE;
          end else begin
            hi_nib = hex_nibble(b);
            phase = PH_LO;
          end
        end
        PH_LO: begin
          phase = PH_IDLE;
          v = {hi_nib, hex_nibble(b)};
          hi_nib = '0;
          if (!is_hex(b) || v == 8'h00) bad = 1;
          else emit(v);
        end
        default: begin
          if (b == ChPercent) phase = PH_HI;
          else if (b == ChPlus) emit(ChSpace);
          else if (is_plain(b)) emit(b);
          else bad = 1;
        end
      endcase
    endfunction

    task report(string msg);
      if (errors < PrintLimit) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_beat(beat_t got);
      beat_t want;
      if (pending_beats.size() == 0) begin
        report($sformatf("beat with nothing expected: data=%h is_status=%b status=%0d last=%b",
                         got.data, got.is_status, got.status, got.last));
        return;
      end
      want = pending_beats.pop_front();
      if (got.data !== want.data)
        report($sformatf("out_byte %h, expected %h", got.data, want.data));
      if (got.is_status !== want.is_status)
        report($sformatf("is_status %b, expected %b", got.is_status, want.is_status));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b (byte %h)", got.last, want.last, want.data));
      if (want.is_status) begin
        strings_done++;
        status_seen[want.status]++;
      end else begin
        bytes_out++;
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [LenW-1:0]     cfg_data;

  udhe_in_if  in_ch ();
  udhe_out_if out_ch ();

  url_decode_html_escape_validator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #5 clk_i = ~clk_i;

  decode_scoreboard sb;

  logic [7:0] str_q[$];     // the string being sent, zero byte included
  int         burst_left;   // characters left in the sender's current burst
  int         reg_writes;
  int         quiet_cycles;
  bit         moved;
  beat_t      seen;

  rx_mode_e   rx_mode;
  int         rx_mode_left;
  int         rx_tick;
  int         rx_run;
  bit         rx_open;

  // Receiver: switches between throttling styles after runs of random length so
  // that stalls land on every beat of an entity and on status beats alike.
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(50, 300);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_FREE:  out_ch.ready <= 1'b1;
      RX_THIRD: out_ch.ready <= (rx_tick % 3 == 0);
      RX_COIN:  out_ch.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_run == 0) begin
          rx_open = !rx_open;
          rx_run = rx_open ? $urandom_range(1, 8) : $urandom_range(3, 30);
        end else begin
          rx_run--;
        end
        out_ch.ready <= rx_open;
      end
    endcase
    rx_tick++;
  end

  // Monitor: both channels are sampled at the rising edge. The output check
  // runs before the input is noted, although a character accepted at this
  // edge cannot have a beat out yet. The watchdog counts edges with no beat
  // and no register write.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = cfg_we;
      if (out_ch.valid && out_ch.ready) begin
        seen = '{data: out_ch.out_byte, is_status: out_ch.is_status,
                 status: status_e'(out_ch.status), last: out_ch.last};
        sb.check_beat(seen);
        moved = 1;
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.take_char(in_ch.src_byte);
        moved = 1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no beat for %0d cycles, %0d beats still expected.",
                 WatchdogLimit, sb.pending_beats.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Sender: characters go out in bursts of random length; most bursts are
  // preceded by a gap, the rest run back to back with the previous one.
  task automatic send_char(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 10);
        @(negedge clk_i) in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.src_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_str();
    foreach (str_q[i]) send_char(str_q[i]);
  endtask

  // Holds the input until every predicted beat has arrived, then lets the
  // pipeline settle so that no character without output is still in flight.
  task automatic drain();
    @(negedge clk_i) in_ch.valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LenW-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i) cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    reg_writes++;
  endtask

  // Registers change only with the block drained. Now and then a write to an
  // index the block does not have goes along, and must leave both alone.
  task automatic set_lengths(input logic [LenW-1:0] lo, input logic [LenW-1:0] hi);
    drain();
    write_reg(CFG_MIN_LENGTH, lo);
    write_reg(CFG_MAX_LENGTH, hi);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? CfgIdxSpareLo : CfgIdxSpareHi,
                LenW'($urandom_range(0, 4095)));
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return "0" + n;
    return ($urandom_range(0, 1) ? "A" : "a") + n - 8'd10;
  endfunction

  function automatic logic [7:0] plain_pick();
    int r;
    r = $urandom_range(0, 64);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    if (r < 62) return 8'("a" + r - 36);
    if (r == 62) return ChStar;
    if (r == 63) return ChMinus;
    return ChUnder;
  endfunction

  function automatic void push_escape(input logic [7:0] v);
    str_q.push_back(ChPercent);
    str_q.push_back(hex_char(v[7:4]));
    str_q.push_back(hex_char(v[3:0]));
  endfunction

  // One well-formed piece: a plain character, a plus, or an escape.
  function automatic void push_token();
    int k;
    int e;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      str_q.push_back(plain_pick());
    end else if (k == 4) begin
      str_q.push_back(ChPlus);
    end else if (k < 9) begin
      push_escape(8'($urandom_range(1, 255)));
    end else begin
      e = $urandom_range(0, 2);
      push_escape(e == 0 ? ChAmp : (e == 1 ? ChLt : ChGt));
    end
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (sb.is_plain(b) || b == ChPercent || b == ChPlus);
    return b;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (sb.is_hex(b));
    return b;
  endfunction

  // Breaks the string at this point; errors that do not end the string are
  // followed by a little random noise that the block has to drop.
  function automatic void push_flaw(input flaw_e flaw);
    int noise;
    case (flaw)
      FL_BAD_CHAR: str_q.push_back(bad_char());
      FL_BAD_HI: begin
        str_q.push_back(ChPercent);
        str_q.push_back(non_hex());
      end
      FL_BAD_LO: begin
        str_q.push_back(ChPercent);
        str_q.push_back(hex_char(4'($urandom_range(0, 15))));
        str_q.push_back(non_hex());
      end
      FL_NUL_ESC: begin
        str_q.push_back(ChPercent);
        str_q.push_back("0");
        str_q.push_back("0");
      end
      FL_CUT_HI: str_q.push_back(ChPercent);
      FL_CUT_LO: begin
        str_q.push_back(ChPercent);
        str_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      default: ;
    endcase
    if (flaw != FL_CUT_HI && flaw != FL_CUT_LO) begin
      noise = $urandom_range(0, 3);
      repeat (noise) str_q.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  // Three strings in four are well formed; the rest carry one flaw.
  function automatic void make_form_string();
    int    n_tok;
    int    pos;
    flaw_e flaw;
    str_q.delete();
    n_tok = $urandom_range(0, 10);
    flaw = ($urandom_range(0, 3) == 0) ? flaw_e'($urandom_range(1, 6)) : FL_NONE;
    pos = $urandom_range(0, n_tok);
    for (int i = 0; i < n_tok; i++) begin
      if (flaw != FL_NONE && flaw != FL_CUT_HI && flaw != FL_CUT_LO && i == pos)
        push_flaw(flaw);
      push_token();
    end
    // Truncated escapes only make sense right before the terminating zero.
    if (flaw == FL_CUT_HI || flaw == FL_CUT_LO || (flaw != FL_NONE && pos == n_tok))
      push_flaw(flaw);
    str_q.push_back(ChNul);
  endfunction

  initial begin
    int live_goal;
    int strings_left;
    int cfg_round;
    int pick;

    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.src_byte = '0;
    out_ch.ready = 1'b0;
    rx_mode = RX_FREE;
    rx_mode_left = 0;
    rx_tick = 0;
    rx_run = 0;
    rx_open = 0;
    burst_left = 0;
    reg_writes = 0;
    quiet_cycles = 0;
    sb = new();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed strings with the reset register values (min 0, max 4095).
    // Pass-through, plus, all three entities in mixed hex case, and 0xFF
    // decoded from an escape: the status must be ok.
    str_q = '{ChUnder, ChPlus, ChPercent, "2", "6", ChPercent, "3", "c",
              ChPercent, "3", "E", ChPercent, "f", "F", ChNul};
    send_str();
    // A byte outside the accepted set.
    str_q = '{8'hFF, ChNul};
    send_str();
    // The escape for zero, followed by a character that must be dropped.
    str_q = '{ChPercent, "0", "0", "A", ChNul};
    send_str();
    // A non-hex digit right after the percent sign.
    str_q = '{ChPercent, "g", ChNul};
    send_str();
    // The string ends halfway through an escape.
    str_q = '{ChPercent, "4", ChNul};
    send_str();

    // Random strings. The register settings start with the extremes and a narrow
    // window, then go random, mostly around the lengths the strings actually reach.
    live_goal = sb.live_items + RandomItems;
    strings_left = 0;
    cfg_round = 0;
    while (sb.live_items < live_goal) begin
      if (strings_left == 0) begin
        pick = (cfg_round < 4) ? cfg_round : $urandom_range(4, 9);
        case (pick)
          0:       set_lengths(12'd0, 12'd0);
          1:       set_lengths(12'd4095, 12'd4095);
          2:       set_lengths(12'd4095, 12'd0);
          3:       set_lengths(12'd2, 12'd8);
          4:       set_lengths(12'd0, 12'd4095);
          9:       set_lengths(LenW'($urandom_range(0, 4095)), LenW'($urandom_range(0, 4095)));
          default: set_lengths(LenW'($urandom_range(0, 5)), LenW'($urandom_range(0, 14)));
        endcase
        cfg_round++;
        strings_left = $urandom_range(3, 8);
      end
      make_form_string();
      send_str();
      strings_left--;
      // Once in a while the sender waits for the result stream to run dry.
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    $display("Ran %0d strings: %0d ok, %0d bad encoding, %0d too long, %0d too short.",
             sb.strings_done, sb.status_seen[ST_OK], sb.status_seen[ST_INV_ENC],
             sb.status_seen[ST_TOO_LONG], sb.status_seen[ST_TOO_SHORT]);
    $display("%0d characters acted on, %0d escaped bytes, %0d register writes, %0d mismatches.",
             sb.live_items, sb.bytes_out, reg_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/udhe_pkg.sv
src/udhe_in_if.sv
src/udhe_out_if.sv
src/udhe_decoder.sv
src/udhe_emitter.sv
src/url_decode_html_escape_validator.sv
test/url_decode_html_escape_validator_tb.sv
